FILE: src/sacl_pkg.sv
// Shared types, constants and helpers for the set-associative cache lookup unit.
// Used by sacl_store, sacl_ctrl, set_assoc_cache_lru_lookup_unit and the dv checker and testbench.
package sacl_pkg;

   localparam int MAX_SET_BITS = 10;
   localparam int MAX_WAYS     = 8;
   localparam int OFFSET_MAX   = 16;

   localparam int WAY_W     = $clog2(MAX_WAYS);
   localparam int SET_W     = MAX_SET_BITS;
   localparam int LINE_AW   = SET_W + WAY_W;
   localparam int SETS      = 1 << SET_W;
   localparam int LINES     = SETS * MAX_WAYS;
   localparam int ADDR_W    = 64;
   localparam int TAG_W     = 62;
   localparam int STAMP_W   = 64;
   localparam int TOTAL_W   = 32;
   localparam int SETB_W    = 4;
   localparam int OFFB_W    = 5;
   localparam int WAYSB_W   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_USED   = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [SETB_W-1:0]  set_bits;
      logic [OFFB_W-1:0]  offset_bits;
      logic [WAYSB_W-1:0] ways_used;
   } cfg_type;

   typedef struct packed {
      logic [LINE_AW-1:0]  rd_addr;
      logic                vrow_rd;
      logic [LINE_AW-1:0]  wr_addr;
      logic                tag_wr;
      logic [TAG_W-1:0]    wr_tag;
      logic                stamp_wr;
      logic [STAMP_W-1:0]  wr_stamp;
      logic                vrow_wr;
      logic [MAX_WAYS-1:0] wr_vrow;
   } store_cmd_type;

   typedef struct packed {
      logic               hit;
      logic               evicted;
      logic [WAY_W-1:0]   way;
      logic [TOTAL_W-1:0] hit_total;
      logic [TOTAL_W-1:0] miss_total;
      logic [TOTAL_W-1:0] eviction_total;
   } result_type;

   function automatic logic [SETB_W-1:0] clamp_set_bits(input logic [SETB_W-1:0] v);
      if (v == '0) return SETB_W'(1);
      if (v > SETB_W'(MAX_SET_BITS)) return SETB_W'(MAX_SET_BITS);
      return v;
   endfunction

   function automatic logic [OFFB_W-1:0] clamp_offset_bits(input logic [OFFB_W-1:0] v);
      if (v == '0) return OFFB_W'(1);
      if (v > OFFB_W'(OFFSET_MAX)) return OFFB_W'(OFFSET_MAX);
      return v;
   endfunction

   function automatic logic [WAYSB_W-1:0] clamp_ways(input logic [WAYSB_W-1:0] v);
      if (v == '0) return WAYSB_W'(1);
      if (v > WAYSB_W'(MAX_WAYS)) return WAYSB_W'(MAX_WAYS);
      return v;
   endfunction

   function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
      return (v == '1) ? v : v + TOTAL_W'(1);
   endfunction

endpackage

FILE: src/sacl_store.sv
// Line storage: tag and stamp memories (one entry per line) and valid rows (one per set).
// Depends on sacl_pkg for widths and the store command struct.
module sacl_store
   import sacl_pkg::*;
(
   input  logic                clock,
   input  store_cmd_type       cmd,
   output logic [TAG_W-1:0]    rd_tag,
   output logic [STAMP_W-1:0]  rd_stamp,
   output logic [MAX_WAYS-1:0] rd_vrow
);

   logic [TAG_W-1:0]    tag_mem   [LINES];
   logic [STAMP_W-1:0]  stamp_mem [LINES];
   logic [MAX_WAYS-1:0] valid_mem [SETS];

   logic [TAG_W-1:0]    rd_tag_ff;
   logic [STAMP_W-1:0]  rd_stamp_ff;
   logic [MAX_WAYS-1:0] rd_vrow_ff;

   always_ff @(posedge clock) begin
      if (cmd.tag_wr) begin
         tag_mem[cmd.wr_addr] <= cmd.wr_tag;
      end
      rd_tag_ff <= tag_mem[cmd.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.stamp_wr) begin
         stamp_mem[cmd.wr_addr] <= cmd.wr_stamp;
      end
      rd_stamp_ff <= stamp_mem[cmd.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.vrow_wr) begin
         valid_mem[cmd.wr_addr[LINE_AW-1:WAY_W]] <= cmd.wr_vrow;
      end
      if (cmd.vrow_rd) begin
         rd_vrow_ff <= valid_mem[cmd.rd_addr[LINE_AW-1:WAY_W]];
      end
   end

   assign rd_tag   = rd_tag_ff;
   assign rd_stamp = rd_stamp_ff;
   assign rd_vrow  = rd_vrow_ff;

endmodule

FILE: src/sacl_ctrl.sv
// Lookup sequencer: clears valid rows after reset, scans the ways of a set one per cycle
// through a shared tag/stamp compare, then writes back the chosen line. Depends on sacl_pkg.
module sacl_ctrl
   import sacl_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ADDR_W-1:0]   req_address,
   output store_cmd_type       cmd,
   input  logic [TAG_W-1:0]    rd_tag,
   input  logic [STAMP_W-1:0]  rd_stamp,
   input  logic [MAX_WAYS-1:0] rd_vrow,
   input  logic                out_free,
   output logic                res_load,
   output result_type          res
);

   state_type state_ff, state_in;

   logic [SET_W-1:0]   set_ff, set_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic [WAYSB_W-1:0] ways_ff, ways_in;
   logic [WAY_W-1:0]   cmp_way_ff, cmp_way_in;
   logic               hit_ff, hit_in;
   logic [WAY_W-1:0]   hit_way_ff, hit_way_in;
   logic               free_ff, free_in;
   logic [WAY_W-1:0]   free_way_ff, free_way_in;
   logic [STAMP_W-1:0] oldest_ff, oldest_in;
   logic [WAY_W-1:0]   lru_way_ff, lru_way_in;
   logic [STAMP_W-1:0] clock_ff, clock_in;
   logic [TOTAL_W-1:0] hits_ff, hits_in;
   logic [TOTAL_W-1:0] misses_ff, misses_in;
   logic [TOTAL_W-1:0] evicts_ff, evicts_in;
   logic [SET_W-1:0]   clr_ff, clr_in;

   logic [SET_W:0]     mask_wide;
   logic [ADDR_W-1:0]  set_shift;
   logic [5:0]         tag_shamt;
   logic [ADDR_W-1:0]  tag_shift;
   logic [SET_W-1:0]   set_calc;
   logic [TAG_W-1:0]   tag_calc;
   logic               line_valid;
   logic               tag_match;
   logic               stamp_older;
   logic               last_way;
   logic [WAY_W-1:0]   chosen;
   logic               evict;

   always_comb begin
      mask_wide = ({{SET_W{1'b0}}, 1'b1} << cfg.set_bits) - (SET_W+1)'(1);
      set_shift = req_address >> cfg.offset_bits;
      set_calc  = set_shift[SET_W-1:0] & mask_wide[SET_W-1:0];
      tag_shamt = {1'b0, cfg.offset_bits} + {2'b00, cfg.set_bits};
      tag_shift = req_address >> tag_shamt;
      tag_calc  = tag_shift[TAG_W-1:0];
   end

   always_comb begin
      line_valid  = rd_vrow[cmp_way_ff];
      tag_match   = line_valid && (rd_tag == tag_ff);
      stamp_older = (cmp_way_ff == '0) || (rd_stamp < oldest_ff);
      last_way    = ({1'b0, cmp_way_ff} == (ways_ff - WAYSB_W'(1)));
      evict       = !hit_ff && !free_ff;
      if (hit_ff) begin
         chosen = hit_way_ff;
      end else if (free_ff) begin
         chosen = free_way_ff;
      end else begin
         chosen = lru_way_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         clock_ff  <= STAMP_W'(1);
         hits_ff   <= '0;
         misses_ff <= '0;
         evicts_ff <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         clock_ff  <= clock_in;
         hits_ff   <= hits_in;
         misses_ff <= misses_in;
         evicts_ff <= evicts_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff      <= set_in;
      tag_ff      <= tag_in;
      ways_ff     <= ways_in;
      cmp_way_ff  <= cmp_way_in;
      hit_ff      <= hit_in;
      hit_way_ff  <= hit_way_in;
      free_ff     <= free_in;
      free_way_ff <= free_way_in;
      oldest_ff   <= oldest_in;
      lru_way_ff  <= lru_way_in;
   end

   always_comb begin
      state_in    = state_ff;
      set_in      = set_ff;
      tag_in      = tag_ff;
      ways_in     = ways_ff;
      cmp_way_in  = cmp_way_ff;
      hit_in      = hit_ff;
      hit_way_in  = hit_way_ff;
      free_in     = free_ff;
      free_way_in = free_way_ff;
      oldest_in   = oldest_ff;
      lru_way_in  = lru_way_ff;
      clock_in    = clock_ff;
      hits_in     = hits_ff;
      misses_in   = misses_ff;
      evicts_in   = evicts_ff;
      clr_in      = clr_ff;

      req_ready = 1'b0;
      res_load  = 1'b0;

      cmd          = '0;
      cmd.rd_addr  = {set_ff, cmp_way_ff + WAY_W'(1)};
      cmd.wr_addr  = {set_ff, chosen};
      cmd.wr_tag   = tag_ff;
      cmd.wr_stamp = clock_ff;
      cmd.wr_vrow  = rd_vrow | (MAX_WAYS'(1) << chosen);

      res.hit            = hit_ff;
      res.evicted        = evict;
      res.way            = chosen;
      res.hit_total      = hit_ff ? sat_inc(hits_ff) : hits_ff;
      res.miss_total     = hit_ff ? misses_ff : sat_inc(misses_ff);
      res.eviction_total = evict ? sat_inc(evicts_ff) : evicts_ff;

      case (state_ff)
         ST_CLEAR: begin
            cmd.wr_addr = {clr_ff, {WAY_W{1'b0}}};
            cmd.wr_vrow = '0;
            cmd.vrow_wr = 1'b1;
            clr_in      = clr_ff + SET_W'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.rd_addr = {set_calc, {WAY_W{1'b0}}};
            cmd.vrow_rd = req_valid;
            if (req_valid) begin
               set_in     = set_calc;
               tag_in     = tag_calc;
               ways_in    = cfg.ways_used;
               cmp_way_in = '0;
               hit_in     = 1'b0;
               free_in    = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stamp_older) begin
               oldest_in  = rd_stamp;
               lru_way_in = cmp_way_ff;
            end
            if (!line_valid && !free_ff) begin
               free_in     = 1'b1;
               free_way_in = cmp_way_ff;
            end
            if (tag_match) begin
               hit_in     = 1'b1;
               hit_way_in = cmp_way_ff;
               state_in   = ST_WRITE;
            end else if (last_way) begin
               state_in = ST_WRITE;
            end else begin
               cmp_way_in = cmp_way_ff + WAY_W'(1);
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               cmd.stamp_wr = 1'b1;
               cmd.tag_wr   = !hit_ff;
               cmd.vrow_wr  = !hit_ff;
               res_load     = 1'b1;
               clock_in     = clock_ff + STAMP_W'(1);
               hits_in      = res.hit_total;
               misses_in    = res.miss_total;
               evicts_in    = res.eviction_total;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: src/set_assoc_cache_lru_lookup_unit.sv
// Set-associative cache tag lookup with LRU replacement.
// Depends on sacl_pkg, sacl_store and sacl_ctrl.
//
// Usage:
//   req_ channel carries one byte address per request. rsp_ channel returns one result
//   per request: hit, evicted, way and the saturating hit, miss and eviction totals.
//   csr_ channel writes set_bits (index 0), offset_bits (index 1) and ways_used
//   (index 2); write it only while no request is in flight. csr_ready is always high.
// Sequence:
//   On acceptance a request reads the set's valid row and way 0; the ways are then
//   compared one at a time through the shared tag/stamp compare (a hit ends the scan
//   early), and the chosen line is written back. The result appears in the output
//   register on the cycle after write-back; the next request is accepted then.
// Reset:
//   Reset clears the valid rows of every set, one set per cycle; req_ready stays
//   low during it. Configuration writes are taken throughout.
// Stall:
//   The output register holds a result until taken; one further request can finish
//   its scan meanwhile and then waits in write-back until the register frees.
module set_assoc_cache_lru_lookup_unit
   import sacl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ADDR_W-1:0]    req_address,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_hit,
   output logic                 rsp_evicted,
   output logic [WAY_W-1:0]     rsp_way,
   output logic [TOTAL_W-1:0]   rsp_hit_total,
   output logic [TOTAL_W-1:0]   rsp_miss_total,
   output logic [TOTAL_W-1:0]   rsp_eviction_total,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   logic [SETB_W-1:0]   set_bits_ff;
   logic [OFFB_W-1:0]   offset_bits_ff;
   logic [WAYSB_W-1:0]  ways_used_ff;
   cfg_type             cfg;

   store_cmd_type       cmd;
   logic [TAG_W-1:0]    rd_tag;
   logic [STAMP_W-1:0]  rd_stamp;
   logic [MAX_WAYS-1:0] rd_vrow;

   logic                out_free;
   logic                res_load;
   result_type          res;
   logic                rsp_valid_ff;
   result_type          rsp_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff    <= SETB_W'(4);
         offset_bits_ff <= OFFB_W'(4);
         ways_used_ff   <= WAYSB_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SET_BITS:    set_bits_ff    <= csr_data[SETB_W-1:0];
            CSR_OFFSET_BITS: offset_bits_ff <= csr_data[OFFB_W-1:0];
            CSR_WAYS_USED:   ways_used_ff   <= csr_data[WAYSB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.set_bits    = clamp_set_bits(set_bits_ff);
      cfg.offset_bits = clamp_offset_bits(offset_bits_ff);
      cfg.ways_used   = clamp_ways(ways_used_ff);
   end

   sacl_store u_store (
      .clock    (clock),
      .cmd      (cmd),
      .rd_tag   (rd_tag),
      .rd_stamp (rd_stamp),
      .rd_vrow  (rd_vrow)
   );

   sacl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_address (req_address),
      .cmd         (cmd),
      .rd_tag      (rd_tag),
      .rd_stamp    (rd_stamp),
      .rd_vrow     (rd_vrow),
      .out_free    (out_free),
      .res_load    (res_load),
      .res         (res)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_ff.hit;
   assign rsp_evicted        = rsp_ff.evicted;
   assign rsp_way            = rsp_ff.way;
   assign rsp_hit_total      = rsp_ff.hit_total;
   assign rsp_miss_total     = rsp_ff.miss_total;
   assign rsp_eviction_total = rsp_ff.eviction_total;

endmodule

FILE: dv/sacl_lookup_checker.sv
// Checker for the set-associative cache lookup unit: watches the request, response and
// register channels, predicts each lookup's hit, way, eviction and totals, and compares.
// Depends on sacl_pkg for widths, register indexes and the result struct.
module sacl_lookup_checker
   import sacl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [ADDR_W-1:0]    req_address,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 rsp_hit,
   input  logic                 rsp_evicted,
   input  logic [WAY_W-1:0]     rsp_way,
   input  logic [TOTAL_W-1:0]   rsp_hit_total,
   input  logic [TOTAL_W-1:0]   rsp_miss_total,
   input  logic [TOTAL_W-1:0]   rsp_eviction_total,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output int                   mismatch_count,
   output int                   results_seen,
   output int                   outstanding
);

   cfg_type            cfg;
   bit                 line_valid [LINES];
   logic [TAG_W-1:0]   line_tag   [LINES];
   logic [STAMP_W-1:0] line_stamp [LINES];
   logic [STAMP_W-1:0] access_clock;
   logic [TOTAL_W-1:0] hits;
   logic [TOTAL_W-1:0] misses;
   logic [TOTAL_W-1:0] evictions;
   result_type         expected_lookups [$];

   function automatic logic [TOTAL_W-1:0] saturate_up(input logic [TOTAL_W-1:0] v);
      return (v == {TOTAL_W{1'b1}}) ? v : v + TOTAL_W'(1);
   endfunction

   function automatic int limit_field(input int v, input int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic result_type lookup_and_replace(input logic [ADDR_W-1:0] addr);
      int                 s;
      int                 b;
      int                 e;
      int                 base;
      int                 w;
      int                 chosen;
      int                 free_way;
      logic [ADDR_W-1:0]  set_idx;
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] oldest;
      bit                 hit;
      bit                 have_free;
      bit                 evict;
      result_type         r;
      s = limit_field(int'(cfg.set_bits), MAX_SET_BITS);
      b = limit_field(int'(cfg.offset_bits), OFFSET_MAX);
      e = limit_field(int'(cfg.ways_used), MAX_WAYS);
      set_idx = (addr >> b) & ((64'd1 << s) - 64'd1);
      tag = TAG_W'(addr >> (b + s));
      base = int'(set_idx) * MAX_WAYS;
      hit = 1'b0;
      have_free = 1'b0;
      evict = 1'b0;
      chosen = 0;
      free_way = 0;
      for (w = 0; w < e; w++) begin
         if (line_valid[base + w] && line_tag[base + w] == tag) begin
            hit = 1'b1;
            chosen = w;
            break;
         end
         if (!line_valid[base + w] && !have_free) begin
            have_free = 1'b1;
            free_way = w;
         end
      end
      if (hit) begin
         hits = saturate_up(hits);
      end else begin
         misses = saturate_up(misses);
         if (have_free) begin
            chosen = free_way;
         end else begin
            oldest = line_stamp[base];
            chosen = 0;
            for (w = 1; w < e; w++) begin
               if (line_stamp[base + w] < oldest) begin
                  oldest = line_stamp[base + w];
                  chosen = w;
               end
            end
            evict = 1'b1;
            evictions = saturate_up(evictions);
         end
         line_valid[base + chosen] = 1'b1;
         line_tag[base + chosen] = tag;
      end
      line_stamp[base + chosen] = access_clock;
      access_clock = access_clock + STAMP_W'(1);
      r.hit = hit;
      r.evicted = evict;
      r.way = WAY_W'(chosen);
      r.hit_total = hits;
      r.miss_total = misses;
      r.eviction_total = evictions;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      int         i;
      if (reset) begin
         for (i = 0; i < LINES; i++) line_valid[i] = 1'b0;
         cfg.set_bits = SETB_W'(4);
         cfg.offset_bits = OFFB_W'(4);
         cfg.ways_used = WAYSB_W'(1);
         access_clock = STAMP_W'(1);
         hits = '0;
         misses = '0;
         evictions = '0;
         expected_lookups.delete();
         mismatch_count = 0;
         results_seen = 0;
         outstanding = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_lookups.size() == 0) begin
               report_mismatch("response with no request outstanding", '0, '0);
            end else begin
               want = expected_lookups.pop_front();
               if (rsp_hit !== want.hit)
                  report_mismatch("hit", 64'(want.hit), 64'(rsp_hit));
               if (rsp_evicted !== want.evicted)
                  report_mismatch("evicted", 64'(want.evicted), 64'(rsp_evicted));
               if (rsp_way !== want.way)
                  report_mismatch("way", 64'(want.way), 64'(rsp_way));
               if (rsp_hit_total !== want.hit_total)
                  report_mismatch("hit_total", 64'(want.hit_total), 64'(rsp_hit_total));
               if (rsp_miss_total !== want.miss_total)
                  report_mismatch("miss_total", 64'(want.miss_total), 64'(rsp_miss_total));
               if (rsp_eviction_total !== want.eviction_total)
                  report_mismatch("eviction_total", 64'(want.eviction_total),
                                  64'(rsp_eviction_total));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SET_BITS:    cfg.set_bits = csr_data[SETB_W-1:0];
               CSR_OFFSET_BITS: cfg.offset_bits = csr_data[OFFB_W-1:0];
               CSR_WAYS_USED:   cfg.ways_used = csr_data[WAYSB_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_lookups.push_back(lookup_and_replace(req_address));
         outstanding = expected_lookups.size();
      end
   end

endmodule

FILE: dv/set_assoc_cache_lru_lookup_unit_test.sv
// Testbench top for the set-associative cache lookup unit: drives address requests,
// register writes and response back-pressure, and gives the verdict.
// Depends on sacl_pkg, set_assoc_cache_lru_lookup_unit and sacl_lookup_checker.
module set_assoc_cache_lru_lookup_unit_test
   import sacl_pkg::*;
();

   localparam int                   RUN_LIMIT        = 400000;
   localparam int                   HOLD_OFF_CYCLES  = 300;
   localparam int                   SETTLE_CYCLES    = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [ADDR_W-1:0]    req_address;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_hit;
   logic                 rsp_evicted;
   logic [WAY_W-1:0]     rsp_way;
   logic [TOTAL_W-1:0]   rsp_hit_total;
   logic [TOTAL_W-1:0]   rsp_miss_total;
   logic [TOTAL_W-1:0]   rsp_eviction_total;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   int          mismatches;
   int          results;
   int          outstanding;
   int          sent = 0;
   int          cycle_count = 0;
   bit          hold_off_req = 1'b0;
   bit          tx_quiet = 1'b0;
   bit          rx_quiet = 1'b0;
   int          cur_s = 4;
   int          cur_b = 4;
   int          cur_e = 1;
   logic [63:0] tag_pool [16];
   logic [63:0] set_pool [4];
   int          tag_n;
   int          set_n;

   set_assoc_cache_lru_lookup_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_evicted        (rsp_evicted),
      .rsp_way            (rsp_way),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   sacl_lookup_checker lookup_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_evicted        (rsp_evicted),
      .rsp_way            (rsp_way),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_miss_total     (rsp_miss_total),
      .rsp_eviction_total (rsp_eviction_total),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .mismatch_count     (mismatches),
      .results_seen       (results),
      .outstanding        (outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("set_assoc_cache_lru_lookup_unit_test: FAIL");
         $finish;
      end
   end

   function automatic int pause_length(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int effective(input int v, input int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [63:0] make_address(input logic [63:0] tag,
                                                input logic [63:0] set_num);
      logic [63:0] off;
      off = {$urandom, $urandom} & ((64'd1 << cur_b) - 64'd1);
      return (tag << (cur_b + cur_s)) | (set_num << cur_b) | off;
   endfunction

   // receiver: random back-pressure, or one long hold-off on demand
   initial begin : receiver
      int n;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            n = pause_length(rx_quiet);
            if (n > 0) begin
               rsp_ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_request(input logic [ADDR_W-1:0] a, input bit eager);
      int gap;
      gap = eager ? 0 : pause_length(tx_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_address <= a;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   // drop valid and wait until every request has its response
   task automatic settle();
      req_valid <= 1'b0;
      wait (results == sent);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DAT_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DAT_W-1:0] sd, input logic [CSR_DAT_W-1:0] od,
                            input logic [CSR_DAT_W-1:0] wd);
      settle();
      write_register(CSR_SET_BITS, sd);
      write_register(CSR_OFFSET_BITS, od);
      write_register(CSR_WAYS_USED, wd);
      cur_s = effective(int'(sd[SETB_W-1:0]), MAX_SET_BITS);
      cur_b = effective(int'(od[OFFB_W-1:0]), OFFSET_MAX);
      cur_e = effective(int'(wd[WAYSB_W-1:0]), MAX_WAYS);
   endtask

   task automatic run_phase(input logic [CSR_DAT_W-1:0] sd, input logic [CSR_DAT_W-1:0] od,
                            input logic [CSR_DAT_W-1:0] wd, input int count,
                            input bit squeeze);
      int          i;
      logic [63:0] a;
      configure(sd, od, wd);
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      tag_n = cur_e + 1 + int'($urandom_range(0, 3));
      for (i = 0; i < tag_n; i++) tag_pool[i] = {$urandom, $urandom};
      set_n = int'($urandom_range(1, 3));
      for (i = 0; i < set_n; i++) set_pool[i] = 64'($urandom_range(0, (1 << cur_s) - 1));
      if (squeeze) hold_off_req = 1'b1;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 85)
            a = make_address(tag_pool[$urandom_range(0, tag_n - 1)],
                             set_pool[$urandom_range(0, set_n - 1)]);
         else
            a = {$urandom, $urandom};
         send_request(a, squeeze && i < 24);
      end
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
   endtask

   initial begin : stimulus
      int t;
      reset = 1'b1;
      req_valid = 1'b0;
      req_address = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SET_BITS;
      csr_data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset split: one way, four set bits, four offset bits
      send_request(64'h0, 1'b0);
      send_request(64'h0, 1'b0);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_request(64'h100, 1'b0);
      send_request(64'h0, 1'b0);
      send_request(64'hF, 1'b0);

      // narrowest split, all eight ways of one set, then LRU replacement
      configure(5'd1, 5'd1, 5'd8);
      for (t = 1; t <= 8; t++) send_request(make_address(64'(t), 64'd0), 1'b0);
      send_request(make_address(64'd9, 64'd0), 1'b0);
      send_request(make_address(64'd2, 64'd0), 1'b0);
      send_request(make_address(64'd10, 64'd0), 1'b0);
      send_request(make_address(64'd2, 64'd1), 1'b0);

      // fewer ways: lines beyond the limit are kept but not searched
      configure(5'd1, 5'd1, 5'd2);
      write_register(CSR_UNUSED_INDEX, 5'h1F);
      send_request(make_address(64'd5, 64'd0), 1'b0);
      send_request(make_address(64'd9, 64'd0), 1'b0);
      send_request(make_address(64'd2, 64'd0), 1'b0);
      configure(5'd1, 5'd1, 5'd8);
      send_request(make_address(64'd5, 64'd0), 1'b0);
      send_request(make_address(64'd7, 64'd0), 1'b0);

      run_phase(5'd1, 5'd1, 5'd1, 40, 1'b0);
      run_phase(5'd10, 5'd16, 5'd8, 60, 1'b0);
      run_phase(5'd0, 5'd0, 5'd0, 30, 1'b0);
      run_phase(5'h1F, 5'h1F, 5'h1F, 60, 1'b0);
      run_phase(5'h10, 5'd17, 5'h18, 30, 1'b0);
      run_phase(5'd3, 5'd5, 5'd4, 60, 1'b1);
      run_phase(5'd2, 5'd8, 5'd2, 60, 1'b0);
      repeat (5)
         run_phase(CSR_DAT_W'($urandom_range(0, 31)), CSR_DAT_W'($urandom_range(0, 31)),
                   CSR_DAT_W'($urandom_range(0, 31)), 50, 1'b0);

      settle();
      if (mismatches == 0 && outstanding == 0)
         $display("set_assoc_cache_lru_lookup_unit_test: PASS");
      else
         $display("set_assoc_cache_lru_lookup_unit_test: FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
src/sacl_pkg.sv
src/sacl_store.sv
src/sacl_ctrl.sv
src/set_assoc_cache_lru_lookup_unit.sv
dv/sacl_lookup_checker.sv
dv/set_assoc_cache_lru_lookup_unit_test.sv
